/* sv/utq_pkg.sv */
package utq_pkg;

   localparam int DEPTH = 16;
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int ID_W  = 16;
   localparam int CNT_W = 8;
   localparam int CMD_W = 2;
   localparam int STS_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_FIND    = 2'd2,
      CMD_REMOVE  = 2'd3
   } command_type;

   localparam logic [STS_W-1:0] STS_OK      = 3'd0;
   localparam logic [STS_W-1:0] STS_INVALID = 3'd1;
   localparam logic [STS_W-1:0] STS_DUP     = 3'd2;
   localparam logic [STS_W-1:0] STS_FULL    = 3'd3;
   localparam logic [STS_W-1:0] STS_NONE    = 3'd4;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic signed [ID_W-1:0]  task_id;
      logic signed [CNT_W-1:0] resource_count;
   } entry_type;

   typedef struct packed {
      logic occupied;
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

/* sv/utq_if.sv */
interface utq_req_if;
   import utq_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic signed [ID_W-1:0]  task_id;
   logic signed [CNT_W-1:0] resource_count;

   modport source (output valid, command, task_id, resource_count, input ready);
   modport sink   (input valid, command, task_id, resource_count, output ready);
endinterface

interface utq_rsp_if;
   import utq_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [STS_W-1:0]        status;
   logic signed [ID_W-1:0]  out_task_id;
   logic signed [CNT_W-1:0] out_resource_count;

   modport source (output valid, status, out_task_id, out_resource_count, input ready);
   modport sink   (input valid, status, out_task_id, out_resource_count, output ready);
endinterface

/* sv/unique_id_task_queue.sv */
// Ordered task queue of DEPTH entries with keyed removal, built as a row of
// cells with the head in cell 0. Enqueue appends at the tail after rejecting
// bad fields (id below 1 or negative count), a duplicate id, or a full queue;
// dequeue pops the head; find returns the record of a queued id; remove takes
// it out and the cells behind it each take their neighbor's word, so order is
// kept. Every word produces exactly one response word. An item is handled at
// accept and then in the execute state: at accept every cell compares its id
// against the request and the match vector is registered; in the execute state
// the queue is updated and the response register is loaded. The response
// register frees the input side while a response is stalled, but the execute
// state waits for that register to drain, so a held rsp_ready holds it up.
module unique_id_task_queue
   import utq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   utq_req_if.sink   req_chan,
   utq_rsp_if.source rsp_chan
);

   state_type state_ff, state_in;

   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [DEPTH-1:0] match_ff, match_in;
   command_type      cmd_ff, cmd_in;
   entry_type        req_ff, req_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [STS_W-1:0] rsp_status_ff, rsp_status_in;
   entry_type        rsp_data_ff, rsp_data_in;

   logic             req_accept;
   logic             exec_active;
   logic             go;

   cell_ctrl_type    ctrl [DEPTH];
   entry_type        cell_data [DEPTH+1];
   logic [DEPTH-1:0] cell_match;
   logic [DEPTH-1:0] shift_mask;
   logic             any_match;
   entry_type        found;
   logic             do_load;
   logic             do_shift_all;
   logic             do_shift_mask;
   logic             bad_fields;

   // ---------------------------------------------------------------- cells
   assign cell_data[DEPTH] = '0;   // nothing behind the last cell

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      utq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl[g]),
         .key       (req_chan.task_id),
         .load_data (req_ff),
         .neighbor  (cell_data[g+1]),
         .data      (cell_data[g]),
         .match     (cell_match[g])
      );
   end

   // ---------------------------------------------------------------- FSM
   assign req_accept = req_chan.valid && req_chan.ready;
   assign go         = exec_active && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      exec_active    = 1'b0;
      case (state_ff)
         S_IDLE:  req_chan.ready = 1'b1;
         S_EXEC:  exec_active    = 1'b1;
         default: exec_active    = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------- request
   // The queue does not change between accept and execute, so the compare
   // runs on the incoming word and only the match vector is kept.
   always_comb begin
      match_in = match_ff;
      cmd_in   = cmd_ff;
      req_in   = req_ff;
      if (req_accept) begin
         match_in               = cell_match;
         cmd_in                 = command_type'(req_chan.command);
         req_in.task_id         = req_chan.task_id;
         req_in.resource_count  = req_chan.resource_count;
      end
   end

   // ---------------------------------------------------------------- execute
   // Ids are unique, so at most one match bit is set; cells at or behind it
   // shift toward the head on remove.
   always_comb begin
      logic [DEPTH-1:0] low;
      any_match = |match_ff;
      found     = '0;
      for (int i = 0; i < DEPTH; i++) begin
         low           = {DEPTH{1'b1}} >> (DEPTH - 1 - i);
         shift_mask[i] = |(match_ff & low);
         if (match_ff[i]) begin
            found = found | cell_data[i];
         end
      end
   end

   assign bad_fields = (req_ff.task_id == '0) || req_ff.task_id[ID_W-1]
                       || req_ff.resource_count[CNT_W-1];

   always_comb begin
      occ_in        = occ_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      do_load       = 1'b0;
      do_shift_all  = 1'b0;
      do_shift_mask = 1'b0;
      if (go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STS_OK;
         rsp_data_in   = '0;
         case (cmd_ff)
            CMD_ENQUEUE: begin
               if (bad_fields) begin
                  rsp_status_in = STS_INVALID;
               end else if (any_match) begin
                  rsp_status_in = STS_DUP;
               end else if (occ_ff == OCC_W'(DEPTH)) begin
                  rsp_status_in = STS_FULL;
               end else begin
                  do_load = 1'b1;
                  occ_in  = occ_ff + 1'b1;
               end
            end
            CMD_DEQUEUE: begin
               if (occ_ff == '0) begin
                  rsp_status_in = STS_NONE;
               end else begin
                  rsp_data_in  = cell_data[0];
                  do_shift_all = 1'b1;
                  occ_in       = occ_ff - 1'b1;
               end
            end
            CMD_FIND, CMD_REMOVE: begin
               if (!any_match) begin
                  rsp_status_in = STS_NONE;
               end else begin
                  rsp_data_in = found;
                  if (cmd_ff == CMD_REMOVE) begin
                     do_shift_mask = 1'b1;
                     occ_in        = occ_ff - 1'b1;
                  end
               end
            end
            default: begin
               rsp_status_in = STS_NONE;
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ctrl[i].occupied = OCC_W'(i) < occ_ff;
         ctrl[i].load     = do_load && (OCC_W'(i) == occ_ff);
         ctrl[i].shift    = do_shift_all || (do_shift_mask && shift_mask[i]);
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff      <= match_in;
      cmd_ff        <= cmd_in;
      req_ff        <= req_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.status             = rsp_status_ff;
   assign rsp_chan.out_task_id        = rsp_data_ff.task_id;
   assign rsp_chan.out_resource_count = rsp_data_ff.resource_count;

   // ---------------------------------------------------------------- checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("occupancy above depth");

   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      exec_active |-> $onehot0(match_ff))
      else $error("id held by more than one cell");

   a_enq_grows: assert property (@(posedge clock) disable iff (reset)
      (go && cmd_ff == CMD_ENQUEUE && rsp_status_in == STS_OK)
      |=> occ_ff == $past(occ_ff) + 1'b1)
      else $error("enqueue did not grow the queue");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STS_OK) |-> rsp_data_ff == '0)
      else $error("rejected word carries data");

endmodule

/* sv/utq_cell.sv */
module utq_cell
   import utq_pkg::*;
(
   input  logic                   clock,
   input  cell_ctrl_type          ctrl,
   input  logic signed [ID_W-1:0] key,
   input  entry_type              load_data,
   input  entry_type              neighbor,
   output entry_type              data,
   output logic                   match
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load) begin
         entry_in = load_data;
      end else if (ctrl.shift) begin
         entry_in = neighbor;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data  = entry_ff;
   assign match = ctrl.occupied && (entry_ff.task_id == key);

endmodule

/* tb/tb_unique_id_task_queue.sv */
`timescale 1ns / 1ps

// Stimulus words go into task_words at time 0; a clocked driver offers them on
// req_chan and a clocked monitor takes response words off rsp_chan. Every
// accepted request word runs through a local queue model right away, and the
// response that model gives waits in awaited_rsp until the block answers.
module tb_unique_id_task_queue;
   import utq_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int POOL_SIZE   = 24;   // more ids than slots, so the queue can fill
   localparam int PHASES      = 10;
   localparam int PHASE_WORDS = 50;
   localparam int HOLD_CYCLES = 150;

   typedef struct {
      command_type             cmd;
      logic signed [ID_W-1:0]  id;
      logic signed [CNT_W-1:0] cnt;
      int                      gap;     // idle cycles after this word is taken
      bit                      drain;   // wait for all responses before offering
   } task_word_type;

   typedef struct {
      logic [STS_W-1:0]        status;
      logic signed [ID_W-1:0]  id;
      logic signed [CNT_W-1:0] cnt;
   } result_word_type;

   logic clock;
   logic reset;

   utq_req_if req_chan ();
   utq_rsp_if rsp_chan ();

   unique_id_task_queue u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Queue model: head at slot 0, same order rules as the block
   // ---------------------------------------------------------------------
   logic signed [ID_W-1:0]  model_ids [DEPTH];
   logic signed [CNT_W-1:0] model_cnts[DEPTH];
   int                      model_occ;

   task_word_type   task_words[$];
   result_word_type awaited_rsp[$];
   task_word_type   offered;
   int              total_words;
   int              words_sent;
   int              words_checked;
   int              mismatches;
   int              cycles;
   int              gap_left;
   int              rx_wait;
   int              rx_style;
   int              rsp_seen;
   int              hold_left;
   int              holds_done;
   logic            next_up;
   result_word_type want;
   logic signed [ID_W-1:0] id_pool[POOL_SIZE];

   function automatic result_word_type predict_queue_op(task_word_type w);
      result_word_type r;
      int              pos;
      int              gone;
      r.status = STS_OK;
      r.id     = '0;
      r.cnt    = '0;
      pos      = -1;
      gone     = -1;
      for (int i = 0; i < model_occ; i++) begin
         if (pos < 0 && model_ids[i] == w.id) pos = i;
      end
      case (w.cmd)
         CMD_ENQUEUE: begin
            // bad fields win over duplicate, duplicate wins over full
            if (w.id < 1 || w.cnt < 0) r.status = STS_INVALID;
            else if (pos >= 0) r.status = STS_DUP;
            else if (model_occ >= DEPTH) r.status = STS_FULL;
            else begin
               model_ids[model_occ]  = w.id;
               model_cnts[model_occ] = w.cnt;
               model_occ++;
            end
         end
         CMD_DEQUEUE: begin
            if (model_occ == 0) r.status = STS_NONE;
            else gone = 0;
         end
         default: begin
            // ids below 1 never get queued, so they simply miss here
            if (pos < 0) r.status = STS_NONE;
            else if (w.cmd == CMD_REMOVE) gone = pos;
            else begin
               r.id  = model_ids[pos];
               r.cnt = model_cnts[pos];
            end
         end
      endcase
      if (gone >= 0) begin
         r.id  = model_ids[gone];
         r.cnt = model_cnts[gone];
         for (int i = gone; i < model_occ - 1; i++) begin
            model_ids[i]  = model_ids[i + 1];
            model_cnts[i] = model_cnts[i + 1];
         end
         model_occ--;
      end
      return r;
   endfunction

   // idle styles: 0 back to back, 1 full 0..11 spread, 2 mostly back to back
   function automatic int idle_draw(int style);
      case (style)
         0:       return 0;
         1:       return $urandom_range(0, 11);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
      endcase
   endfunction

   task automatic add_word(command_type c, int id, int cnt, int gap, bit drain);
      task_word_type w;
      w.cmd   = c;
      w.id    = ID_W'(id);
      w.cnt   = CNT_W'(cnt);
      w.gap   = gap;
      w.drain = drain;
      task_words.push_back(w);
   endtask

   task automatic report(string field, int exp_val, int got_val);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, got_val);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic build_directed();
      // empty queue answers
      add_word(CMD_DEQUEUE, 0, 0, 0, 0);
      add_word(CMD_REMOVE, 5, 0, 0, 0);
      // bad fields: zero id, most negative id and count, negative count alone
      add_word(CMD_ENQUEUE, 0, 0, 0, 0);
      add_word(CMD_ENQUEUE, -32768, -128, 0, 0);
      add_word(CMD_ENQUEUE, 7, -1, 0, 0);
      // extremes that are legal
      add_word(CMD_ENQUEUE, 32767, 127, 0, 0);
      add_word(CMD_ENQUEUE, 1, 0, 0, 0);
      add_word(CMD_ENQUEUE, 32767, 3, 0, 0);      // duplicate
      add_word(CMD_FIND, 32767, -1, 0, 0);
      add_word(CMD_REMOVE, -32768, 0, 0, 0);      // id below 1 never queued
      // fill up to DEPTH, then a new id saturates and a duplicate still
      // reports duplicate rather than full
      for (int i = 0; i < DEPTH - 2; i++)
         add_word(CMD_ENQUEUE, 200 + i, i, 0, 0);
      add_word(CMD_ENQUEUE, 300, 9, 0, 0);
      add_word(CMD_ENQUEUE, 1, 9, 0, 0);
      // removal from the middle keeps order, then pop the head
      add_word(CMD_REMOVE, 205, 0, 0, 0);
      add_word(CMD_DEQUEUE, 0, 0, 0, 0);
   endtask

   task automatic build_random();
      int          style;
      int          bias;
      int          roll;
      command_type c;
      id_pool[0] = 16'sd1;
      id_pool[1] = 16'sd32767;
      for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom_range(2, 32766));
      for (int ph = 0; ph < PHASES; ph++) begin
         style = $urandom_range(0, 2);
         bias  = ph % 3;   // 0 filling, 1 draining, 2 mixed
         for (int k = 0; k < PHASE_WORDS; k++) begin
            roll = $urandom_range(0, 99);
            case (bias)
               0:       c = (roll < 70) ? CMD_ENQUEUE : command_type'(roll % 3 + 1);
               1:       c = (roll < 15) ? CMD_ENQUEUE :
                            (roll < 50) ? CMD_DEQUEUE :
                            (roll < 65) ? CMD_FIND : CMD_REMOVE;
               default: c = command_type'(roll % 4);
            endcase
            if ($urandom_range(0, 9) == 0)
               // noise: any command, any bit pattern
               add_word(command_type'($urandom_range(0, 3)), int'(16'($urandom)),
                        int'(8'($urandom)), idle_draw(style), k == 0 && ph % 3 == 0);
            else
               add_word(c, id_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom_range(0, 127),
                        idle_draw(style), k == 0 && ph % 3 == 0);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Request driver: one word held on req_chan until taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left = 0;
         words_sent <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            awaited_rsp.push_back(predict_queue_op(offered));
            words_sent <= words_sent + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            next_up = 1'b0;
            if (gap_left != 0) begin
               gap_left--;
            end else if (task_words.size() != 0) begin
               // a drain word waits until every response is back, as counted by
               // the monitor in words_checked
               if (!task_words[0].drain ||
                   words_sent + (req_chan.valid ? 1 : 0) == words_checked) begin
                  offered  = task_words.pop_front();
                  gap_left = offered.gap;
                  next_up  = 1'b1;
               end
            end
            req_chan.valid <= next_up;
            if (next_up) begin
               req_chan.command        <= offered.cmd;
               req_chan.task_id        <= offered.id;
               req_chan.resource_count <= offered.cnt;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Long receiver hold-off, twice, while the driver keeps offering: the
   // response register fills and the block must push back on req_chan
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < 2 && words_sent >= 150 + 250 * holds_done) begin
         hold_left  <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor and checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_wait  = 0;
         rx_style = 0;
         rsp_seen = 0;
         words_checked <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: response word with nothing expected, got status %0d",
                        $time, rsp_chan.status);
               mismatches++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_chan.status !== want.status)
                  report("status", want.status, rsp_chan.status);
               if (rsp_chan.out_task_id !== want.id)
                  report("out_task_id", want.id, rsp_chan.out_task_id);
               if (rsp_chan.out_resource_count !== want.cnt)
                  report("out_resource_count", want.cnt, rsp_chan.out_resource_count);
               words_checked <= words_checked + 1;
            end
            rsp_seen++;
            // new stall style every 40 responses
            if (rsp_seen % 40 == 0) rx_style = $urandom_range(0, 2);
            rx_wait = idle_draw(rx_style);
         end
         rsp_chan.ready <= (hold_left == 0 && rx_wait == 0);
         if (rx_wait != 0) rx_wait--;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset                   = 1'b1;
      cycles                  = 0;
      mismatches              = 0;
      model_occ               = 0;
      req_chan.valid          = 1'b0;
      req_chan.command        = CMD_ENQUEUE;
      req_chan.task_id        = '0;
      req_chan.resource_count = '0;
      rsp_chan.ready          = 1'b0;
      build_directed();
      build_random();
      total_words = task_words.size();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      do
         @(posedge clock);
      while (words_sent != total_words || words_checked != words_sent);
      // a little slack so a stray extra response word would still be caught
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
